FILE: sv/fmtr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fmtr_pkg;

	// Queue depth between the classifier and the emitter
	localparam int QUEUE_DEPTH = 2;

	localparam int CHAR_W = 8;
	localparam int IDX_W  = 3;

	// ASCII codes
	localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;
	localparam logic [CHAR_W-1:0] CH_PCT   = 8'h25;
	localparam logic [CHAR_W-1:0] CH_QUOTE = 8'h27;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_ONE   = 8'h31;
	localparam logic [CHAR_W-1:0] CH_SIX   = 8'h36;
	localparam logic [CHAR_W-1:0] CH_EIGHT = 8'h38;
	localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UP_I  = 8'h49;
	localparam logic [CHAR_W-1:0] CH_UP_K  = 8'h4B;
	localparam logic [CHAR_W-1:0] CH_UP_X  = 8'h58;
	localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5A;
	localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LO_K  = 8'h6B;
	localparam logic [CHAR_W-1:0] CH_LO_L  = 8'h6C;
	localparam logic [CHAR_W-1:0] CH_LO_X  = 8'h78;
	localparam logic [CHAR_W-1:0] CH_LO_Y  = 8'h79;
	localparam logic [CHAR_W-1:0] CH_LO_Z  = 8'h7A;

	typedef enum logic [1:0] {
		PH_PLAIN,
		PH_PCT,
		PH_FLAGS,
		PH_WIDTH
	} phase_t;

	typedef enum logic [0:0] {
		OP_CHAR,
		OP_STR
	} op_t;

	typedef enum logic [2:0] {
		STR_08X_LO,
		STR_08X_UP,
		STR_LL,
		STR_016_LO,
		STR_016_UP
	} str_t;

	typedef struct packed {
		op_t              op;
		str_t             sid;
		logic [CHAR_W-1:0] chr;
	} cmd_t;

	function automatic logic [IDX_W-1:0] str_len(input str_t sid);
		logic [IDX_W-1:0] len;
		unique case (sid)
			STR_08X_LO, STR_08X_UP: len = 3'd3;
			STR_LL:                 len = 3'd2;
			STR_016_LO, STR_016_UP: len = 3'd6;
			default:                len = 3'd1;
		endcase
		return len;
	endfunction

	function automatic logic [CHAR_W-1:0] str_char(input str_t sid, input logic [IDX_W-1:0] idx);
		logic [CHAR_W-1:0] c;
		logic              upper;
		upper = (sid == STR_08X_UP) || (sid == STR_016_UP);
		c = CH_NUL;
		unique case (sid)
			STR_08X_LO, STR_08X_UP: begin
				unique case (idx)
					3'd0:    c = CH_ZERO;
					3'd1:    c = CH_EIGHT;
					default: c = upper ? CH_UP_X : CH_LO_X;
				endcase
			end
			STR_LL: c = CH_LO_L;
			STR_016_LO, STR_016_UP: begin
				unique case (idx)
					3'd0:       c = CH_ZERO;
					3'd1:       c = CH_ONE;
					3'd2:       c = CH_SIX;
					3'd3, 3'd4: c = CH_LO_L;
					default:    c = upper ? CH_UP_X : CH_LO_X;
				endcase
			end
			default: c = CH_NUL;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

FILE: sv/fmtr_front.sv
`timescale 1ns / 1ps
`default_nettype none

module fmtr_front (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic                       cfg_wdata,
	input  wire logic                       acc,
	input  wire logic [fmtr_pkg::CHAR_W-1:0] char_in,
	output fmtr_pkg::cmd_t                  cmd,
	output logic                            push,
	output fmtr_pkg::phase_t                phase
);
	import fmtr_pkg::*;

	phase_t phase_q;
	phase_t phase_d;
	logic   ptr64_q;
	logic   emit;

	logic   is_flag;
	logic   is_letter;
	logic   w_emit;
	cmd_t   w_cmd;
	phase_t w_phase;

	assign is_flag = (char_in == CH_MINUS) || (char_in == CH_PLUS) || (char_in == CH_ZERO) ||
		(char_in == CH_SPACE) || (char_in == CH_HASH) || (char_in == CH_QUOTE) ||
		(char_in == CH_UP_I);
	assign is_letter = ((char_in >= CH_LO_A) && (char_in <= CH_LO_Z)) ||
		((char_in >= CH_UP_A) && (char_in <= CH_UP_Z));

	// width/precision scanning, shared by every phase past the '%'
	always_comb begin
		w_emit     = 1'b1;
		w_cmd.op   = OP_CHAR;
		w_cmd.sid  = STR_LL;
		w_cmd.chr  = char_in;
		w_phase    = PH_PLAIN;
		priority if (char_in == CH_NUL) begin
			w_phase = PH_PLAIN;
		end else if (!is_letter) begin
			w_phase = PH_WIDTH;
		end else if (char_in == CH_LO_Y) begin
			w_cmd.op = OP_STR;
			w_emit   = ptr64_q;
		end else begin
			w_phase = PH_PLAIN;
		end
	end

	always_comb begin
		emit     = 1'b1;
		cmd.op   = OP_CHAR;
		cmd.sid  = STR_LL;
		cmd.chr  = char_in;
		phase_d  = phase_q;
		unique case (phase_q)
			PH_PLAIN: begin
				phase_d = (char_in == CH_PCT) ? PH_PCT : PH_PLAIN;
			end
			PH_PCT: begin
				priority if (char_in == CH_UP_K) begin
					cmd.op  = OP_STR;
					cmd.sid = ptr64_q ? STR_016_UP : STR_08X_UP;
					phase_d = PH_PLAIN;
				end else if (char_in == CH_LO_K) begin
					cmd.op  = OP_STR;
					cmd.sid = ptr64_q ? STR_016_LO : STR_08X_LO;
					phase_d = PH_PLAIN;
				end else if ((char_in == CH_PCT) || (char_in == CH_NUL)) begin
					phase_d = PH_PLAIN;
				end else if (is_flag) begin
					phase_d = PH_FLAGS;
				end else begin
					emit    = w_emit;
					cmd     = w_cmd;
					phase_d = w_phase;
				end
			end
			PH_FLAGS: begin
				priority if (is_flag) begin
					phase_d = PH_FLAGS;
				end else begin
					emit    = w_emit;
					cmd     = w_cmd;
					phase_d = w_phase;
				end
			end
			PH_WIDTH: begin
				emit    = w_emit;
				cmd     = w_cmd;
				phase_d = w_phase;
			end
			default: begin
				phase_d = PH_PLAIN;
			end
		endcase
	end

	assign push  = acc && emit;
	assign phase = phase_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PLAIN;
			ptr64_q <= 1'b1;
		end else begin
			if (acc) begin
				phase_q <= phase_d;
			end
			if (cfg_we) begin
				ptr64_q <= cfg_wdata;
			end
		end
	end

endmodule

`default_nettype wire

FILE: sv/fmtr_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module fmtr_queue #(
	parameter int DEPTH = fmtr_pkg::QUEUE_DEPTH
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  wire fmtr_pkg::cmd_t wdata,
	input  wire logic   pop,
	output fmtr_pkg::cmd_t rdata,
	output logic        full,
	output logic        empty
);
	import fmtr_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: sv/fmtr_back.sv
`timescale 1ns / 1ps
`default_nettype none

module fmtr_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire fmtr_pkg::cmd_t              head,
	input  wire logic                        empty,
	output logic                             pop,
	output logic [fmtr_pkg::IDX_W-1:0]       idx,
	output logic                             res_valid,
	input  wire logic                        res_ready,
	output logic [fmtr_pkg::CHAR_W-1:0]      char_out,
	output logic                             last_of_run
);
	import fmtr_pkg::*;

	logic [IDX_W-1:0]  idx_q;
	logic              valid_q;
	logic [CHAR_W-1:0] char_q;
	logic              last_q;

	logic              load;
	logic [CHAR_W-1:0] nxt_char;
	logic              nxt_last;

	assign load = !empty && (!valid_q || res_ready);

	always_comb begin
		unique case (head.op)
			OP_CHAR: begin
				nxt_char = head.chr;
				nxt_last = 1'b1;
			end
			OP_STR: begin
				nxt_char = str_char(head.sid, idx_q);
				nxt_last = (idx_q == str_len(head.sid) - 3'd1);
			end
			default: begin
				nxt_char = head.chr;
				nxt_last = 1'b1;
			end
		endcase
	end

	assign pop = load && nxt_last;

	always_ff @(posedge clk) begin
		if (load) begin
			char_q <= nxt_char;
			last_q <= nxt_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
			end else if (res_ready) begin
				valid_q <= 1'b0;
			end
			if (load) begin
				idx_q <= nxt_last ? '0 : idx_q + 3'd1;
			end
		end
	end

	assign idx         = idx_q;
	assign res_valid   = valid_q;
	assign char_out    = char_q;
	assign last_of_run = last_q;

endmodule

`default_nettype wire

FILE: sv/format_specifier_rewriter_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Format specifier rewriter. Feed one byte of a printf-style format string per
// transaction on char_in (a zero byte ends the string and is echoed); the block
// returns the rewritten string one byte per transaction on char_out, with
// last_of_run set on the final byte caused by each input byte. After '%', a 'k'
// or 'K' expands to "08x"/"08X" (cfg_wdata written 0) or "016llx"/"016llX"
// (written 1, the reset value); a 'y' conversion letter becomes "ll" in 64-bit
// mode and produces nothing in 32-bit mode. Rate: ordinary bytes stream at one
// per clock while res_ready is high and the queue has room, via a queue entry
// and the output register to char_out. An expansion emits its bytes (2, 3 or
// 6) one per clock while res_ready is high, via the emitter's single-byte output
// register; the classifier keeps accepting input while the QUEUE_DEPTH-entry
// command queue has room. Write the mode only while the block is idle.
module format_specifier_rewriter_core #(
	parameter int QUEUE_DEPTH = fmtr_pkg::QUEUE_DEPTH
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic                        cfg_wdata,
	input  wire logic                        char_valid,
	output logic                             char_ready,
	input  wire logic [fmtr_pkg::CHAR_W-1:0] char_in,
	output logic                             res_valid,
	input  wire logic                        res_ready,
	output logic [fmtr_pkg::CHAR_W-1:0]      char_out,
	output logic                             last_of_run
);
	import fmtr_pkg::*;

	logic             acc;
	logic             q_push;
	logic             q_pop;
	logic             q_full;
	logic             q_empty;
	cmd_t             q_wdata;
	cmd_t             q_head;
	phase_t           phase;
	logic [IDX_W-1:0] idx;

	// accept whenever the command queue has a free slot
	assign char_ready = !q_full;
	assign acc        = char_valid && char_ready;

	// classify each byte into a command, track the scan phase
	fmtr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.acc       (acc),
		.char_in   (char_in),
		.cmd       (q_wdata),
		.push      (q_push),
		.phase     (phase)
	);

	// decouple classification from emission
	fmtr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_head),
		.full   (q_full),
		.empty  (q_empty)
	);

	// expand commands into output bytes, one per cycle while res_ready allows
	fmtr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (q_head),
		.empty       (q_empty),
		.pop         (q_pop),
		.idx         (idx),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.char_out    (char_out),
		.last_of_run (last_of_run)
	);

`ifndef SYNTHESIS
	// never push into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_full))
		else $error("command pushed into full queue");

	// a partial expansion always belongs to a string command at the queue head
	a_idx_in_str: assert property (@(posedge clk) disable iff (!arst_n)
		(idx != '0) |-> (!q_empty && q_head.op == OP_STR))
		else $error("expansion index without string command");

	// a terminator returns scanning to plain text
	a_nul_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && char_in == CH_NUL) |=> (phase == PH_PLAIN))
		else $error("terminator did not reset scan phase");
`endif

endmodule

`default_nettype wire

FILE: tb/format_specifier_rewriter_core_test.sv
`timescale 1ns / 1ps

module format_specifier_rewriter_core_test;
	import fmtr_pkg::*;

	localparam int SETTLE_CYCLES  = 12;
	localparam int WATCHDOG_LIMIT = 2000;

	localparam logic [CHAR_W-1:0] CH_DOT  = 8'h2E;
	localparam logic [CHAR_W-1:0] CH_STAR = 8'h2A;

	typedef struct packed {
		logic [CHAR_W-1:0] chr;
		logic              tail;
	} out_char_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic              cfg_wdata = 1'b0;
	logic              char_valid = 1'b0;
	logic              char_ready;
	logic [CHAR_W-1:0] char_in = CH_NUL;
	logic              res_valid;
	logic              res_ready = 1'b0;
	logic [CHAR_W-1:0] char_out;
	logic              last_of_run;

	// Format bytes waiting to be sent, and rewritten bytes still to come back
	logic [CHAR_W-1:0] format_q[$];
	out_char_t         rewritten_q[$];

	// Shadow copy of the block's scan state and pointer mode
	phase_t fmt_phase = PH_PLAIN;
	logic   wide_mode = 1'b1;

	logic allow_idle = 1'b1;
	int   send_gap = 0;
	int   stall_left = 0;
	int   idle_cycles = 0;
	int   mismatch_count = 0;

	format_specifier_rewriter_core u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.char_valid  (char_valid),
		.char_ready  (char_ready),
		.char_in     (char_in),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.char_out    (char_out),
		.last_of_run (last_of_run)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Rewrite prediction
	// ------------------------------------------------------------------

	function automatic bit is_flag_char(input logic [CHAR_W-1:0] c);
		return c == CH_MINUS || c == CH_PLUS || c == CH_ZERO || c == CH_SPACE ||
			c == CH_HASH || c == CH_QUOTE || c == CH_UP_I;
	endfunction

	function automatic bit is_alpha(input logic [CHAR_W-1:0] c);
		return (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z);
	endfunction

	task automatic emit(input logic [CHAR_W-1:0] c);
		rewritten_q.push_back('{chr: c, tail: 1'b0});
	endtask

	task automatic emit_str(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			emit(s[i]);
	endtask

	// Width/precision scan, shared by every phase inside a specifier
	task automatic close_spec(input logic [CHAR_W-1:0] c);
		if (c == CH_NUL) begin
			emit(CH_NUL);
			fmt_phase = PH_PLAIN;
		end else if (!is_alpha(c)) begin
			emit(c);
			fmt_phase = PH_WIDTH;
		end else begin
			fmt_phase = PH_PLAIN;
			// 'y' turns into "ll" for 64-bit, vanishes for 32-bit
			if (c == CH_LO_Y) begin
				if (wide_mode)
					emit_str("ll");
			end else begin
				emit(c);
			end
		end
	endtask

	task automatic rewrite_char(input logic [CHAR_W-1:0] c);
		int first;
		first = rewritten_q.size();
		case (fmt_phase)
			PH_PLAIN: begin
				emit(c);
				fmt_phase = (c == CH_PCT) ? PH_PCT : PH_PLAIN;
			end
			PH_PCT: begin
				if (c == CH_UP_K) begin
					emit_str(wide_mode ? "016llX" : "08X");
					fmt_phase = PH_PLAIN;
				end else if (c == CH_LO_K) begin
					emit_str(wide_mode ? "016llx" : "08x");
					fmt_phase = PH_PLAIN;
				end else if (c == CH_PCT || c == CH_NUL) begin
					emit(c);
					fmt_phase = PH_PLAIN;
				end else if (is_flag_char(c)) begin
					emit(c);
					fmt_phase = PH_FLAGS;
				end else begin
					close_spec(c);
				end
			end
			PH_FLAGS: begin
				if (is_flag_char(c))
					emit(c);
				else
					close_spec(c);
			end
			default: close_spec(c);
		endcase
		// Mark the final byte of this run, if there is one
		if (rewritten_q.size() > first)
			rewritten_q[$].tail = 1'b1;
	endtask

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	task automatic push_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			format_q.push_back(s[i]);
	endtask

	function automatic logic [CHAR_W-1:0] pick_flag();
		case ($urandom_range(0, 6))
			0:       return CH_MINUS;
			1:       return CH_PLUS;
			2:       return CH_ZERO;
			3:       return CH_SPACE;
			4:       return CH_HASH;
			5:       return CH_QUOTE;
			default: return CH_UP_I;
		endcase
	endfunction

	function automatic logic [CHAR_W-1:0] pick_letter();
		if ($urandom_range(0, 1) != 0)
			return 8'(CH_LO_A + $urandom_range(0, 25));
		return 8'(CH_UP_A + $urandom_range(0, 25));
	endfunction

	// One conversion: '%', flags, width/precision, then a closing byte (mostly a letter)
	task automatic add_spec();
		format_q.push_back(CH_PCT);
		repeat ($urandom_range(0, 2))
			format_q.push_back(pick_flag());
		repeat ($urandom_range(0, 2)) begin
			case ($urandom_range(0, 13))
				10:      format_q.push_back(CH_DOT);
				11:      format_q.push_back(CH_STAR);
				12:      format_q.push_back(CH_PCT);
				13:      format_q.push_back(8'($urandom_range(128, 255)));
				default: format_q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
			endcase
		end
		case ($urandom_range(0, 11))
			0, 1:    format_q.push_back(CH_LO_K);
			2:       format_q.push_back(CH_UP_K);
			3, 4:    format_q.push_back(CH_LO_Y);
			5:       format_q.push_back(CH_PCT);
			6:       format_q.push_back(CH_UP_I);
			7:       format_q.push_back(CH_NUL);
			8:       format_q.push_back(8'($urandom_range(0, 255)));
			default: format_q.push_back(pick_letter());
		endcase
	endtask

	// Mostly well-formed strings with random content, some raw noise
	task automatic add_format_string();
		repeat ($urandom_range(1, 4)) begin
			case ($urandom_range(0, 9))
				0, 1: begin
					repeat ($urandom_range(1, 4))
						format_q.push_back(8'($urandom_range(1, 255)));
				end
				2:       format_q.push_back(8'($urandom_range(0, 255)));
				default: add_spec();
			endcase
		end
		if ($urandom_range(0, 9) != 0)
			format_q.push_back(CH_NUL);
	endtask

	// Wait until every byte is sent and every rewritten byte has come back,
	// then give a dropped 'y' time to clear the pipeline
	task automatic wait_drained();
		do
			@(negedge clk);
		while (format_q.size() != 0 || char_valid || rewritten_q.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_pointer_mode(input logic wide);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= wide;
		@(posedge clk);
		cfg_we    <= 1'b0;
		wide_mode = wide;
	endtask

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $time, msg);
		mismatch_count++;
	endtask

	// ------------------------------------------------------------------
	// Character driver: advance on acceptance, hold while stalled
	// ------------------------------------------------------------------

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_valid <= 1'b0;
			char_in    <= CH_NUL;
			send_gap = 0;
		end else if (!char_valid || char_ready) begin
			if (char_valid)
				rewrite_char(char_in);
			if (send_gap != 0) begin
				send_gap = send_gap - 1;
				char_valid <= 1'b0;
			end else if (allow_idle && $urandom_range(0, 7) == 0) begin
				// Start an idle burst of random length, beginning with this cycle
				send_gap = $urandom_range(0, 4);
				char_valid <= 1'b0;
			end else if (format_q.size() != 0) begin
				char_in    <= format_q.pop_front();
				char_valid <= 1'b1;
			end else begin
				char_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Result monitor: check each transaction against the oldest prediction
	// ------------------------------------------------------------------

	always @(posedge clk or negedge arst_n) begin : check_results
		out_char_t want;
		if (!arst_n) begin
			res_ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (res_valid && res_ready) begin
				if (rewritten_q.size() == 0) begin
					report_mismatch($sformatf("unexpected char_out 0x%02h", char_out));
				end else begin
					want = rewritten_q.pop_front();
					if (char_out !== want.chr)
						report_mismatch($sformatf("char_out 0x%02h, expected 0x%02h",
							char_out, want.chr));
					if (last_of_run !== want.tail)
						report_mismatch($sformatf("last_of_run %b, expected %b on 0x%02h",
							last_of_run, want.tail, want.chr));
				end
			end
			if (stall_left != 0) begin
				stall_left = stall_left - 1;
				res_ready <= 1'b0;
			end else if (allow_idle && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 4);
				res_ready <= 1'b0;
			end else begin
				res_ready <= 1'b1;
			end
		end
	end

	// Drop the run if no transaction moves on either side for too long
	always @(posedge clk) begin
		if (!arst_n || (char_valid && char_ready) || (res_valid && res_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed pass in the reset (64-bit) mode
		push_text("%k%K%%%y");
		push_text("% I5I");      // 'I' as flag, then as conversion in width
		push_text("%'%k");       // '%' among flags, then 'k' after width
		push_text("%");
		format_q.push_back(CH_NUL);
		push_text("%#");
		format_q.push_back(CH_NUL);
		push_text("%9");
		format_q.push_back(8'hFF);
		format_q.push_back(CH_NUL);
		format_q.push_back(CH_NUL);
		format_q.push_back(8'hFF);
		format_q.push_back(CH_NUL);
		wait_drained();

		set_pointer_mode(1'b0);
		while (format_q.size() < 130)
			add_format_string();
		wait_drained();

		set_pointer_mode(1'b1);
		while (format_q.size() < 130)
			add_format_string();
		wait_drained();

		// Last part at full rate on both sides
		set_pointer_mode(1'b0);
		allow_idle = 1'b0;
		while (format_q.size() < 140)
			add_format_string();
		wait_drained();

		if (rewritten_q.size() != 0)
			report_mismatch($sformatf("%0d rewritten chars never arrived", rewritten_q.size()));
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: filelist.f
sv/fmtr_pkg.sv
sv/fmtr_front.sv
sv/fmtr_queue.sv
sv/fmtr_back.sv
sv/format_specifier_rewriter_core.sv
tb/format_specifier_rewriter_core_test.sv
